// ===== design/uvc_payload_packetizer_assert.svh =====
// Assertion macros for the payload packetizer checker
`ifndef UVC_PAYLOAD_PACKETIZER_ASSERT_SVH
`define UVC_PAYLOAD_PACKETIZER_ASSERT_SVH

// Clocked assertion, held off during reset
`define UVCPK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the following cycle
`define UVCPK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/uvcpk_pkg.sv =====
`timescale 1ns / 1ps

package uvcpk_pkg;

    localparam int FRAME_COUNT_BITS_DEF = 24;
    localparam int BYTE_W               = 8;
    localparam int FRAME_LEN_W          = 24;
    localparam int PKT_SIZE_W           = 10;
    localparam int CFG_W                = 24;
    localparam int CFG_IDX_W            = 1;
    localparam int TDATA_W              = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PKT_SIZE  = 1'b1;

    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 24'd4096;
    localparam logic [PKT_SIZE_W-1:0]  PKT_SIZE_RST  = 10'd64;
    localparam logic [PKT_SIZE_W-1:0]  PKT_SIZE_MIN  = 10'd3;
    localparam logic [PKT_SIZE_W-1:0]  HDR_BYTES     = 10'd2;

    localparam logic [BYTE_W-1:0] HDR_LEN = 8'h02;
    localparam int FID_POS = 0;
    localparam int EOF_POS = 1;

    typedef struct packed {
        logic [BYTE_W-1:0]     out_byte;
        logic                  packet_end;
        logic [PKT_SIZE_W-1:0] packet_length;
        logic                  buffer_index;
        logic                  run_last;
    } res_t;

endpackage

// ===== design/uvc_payload_packetizer.sv =====
`timescale 1ns / 1ps
// USB video payload packetizer.
// Input stream s_*: one frame byte per transfer in s_tdata.
// Output stream m_*: packet bytes. Each packet opens with the header length
// byte and the flags byte (frame-ID, end-of-frame), then carries frame data.
// m_tdata holds out_byte, packet_end and packet_length, m_tuser the endpoint
// buffer and m_tlast marks the last output caused by one input byte.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 frame length, 1 packet size); write only while the block is idle.
// An accepted byte reaches m_* through the output register, after the two
// header bytes when it opens a packet.
// Throughput: one byte per cycle inside a packet while m_tready is high; at a
// packet start the length byte goes to the output register, the flags and data
// bytes to a two-entry queue behind it, and s_tready stays low until it drains.
// Reset clears all counters, sets the frame length to 4096 and the packet
// size to 64; the first frame carries frame-ID 0.
// When m_tvalid is high and m_tready is low the output register holds and s_tready drops.
module uvc_payload_packetizer #(
    parameter int FRAME_COUNT_BITS = uvcpk_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [uvcpk_pkg::BYTE_W-1:0]     s_tdata,    // [7:0] data_byte
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] out_byte, [8] packet_end, [18:9] packet_length, [23:19] zero
    output logic [uvcpk_pkg::TDATA_W-1:0]    m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic                             m_tlast,
    output logic                             m_tuser,    // [0] buffer_index
    input  logic                             cfg_we,
    input  logic [uvcpk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uvcpk_pkg::CFG_W-1:0]      cfg_data
);
    import uvcpk_pkg::*;

    localparam int FW    = FRAME_COUNT_BITS;
    localparam int EXT_W = (FW > FRAME_LEN_W) ? FW : FRAME_LEN_W;
    localparam int CMP_W = (FW > PKT_SIZE_W) ? FW : PKT_SIZE_W;
    localparam logic [EXT_W-1:0] CNT_MAX = {EXT_W{1'b1}} >> (EXT_W - FW);

    logic [FRAME_LEN_W-1:0] frame_length_reg;
    logic [PKT_SIZE_W-1:0]  packet_size_reg;
    logic [FW-1:0]          frame_pos_reg, frame_pos_next;
    logic [PKT_SIZE_W-1:0]  pkt_pos_reg, pkt_pos_next;
    logic                   frame_id_reg, frame_id_next;
    logic                   toggle_reg, toggle_next;
    logic [PKT_SIZE_W-1:0]  cur_len_reg, cur_len_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             q_cnt_reg, q_cnt_next;
    res_t                   out_reg, out_next;
    res_t                   q0_reg, q0_next;
    res_t                   q1_reg, q1_next;

    logic [EXT_W-1:0]      fl_ext, flen_ext;
    logic [FW-1:0]         flen, fp0, remain, fp_base, fp_inc;
    logic [CMP_W-1:0]      remain_c;
    logic [PKT_SIZE_W-1:0] psz, room, take, new_len, len_eff, pp_base, pp_inc;
    logic                  start, eof, fid_new, pkt_end, buf_idx, accept, load;
    logic [BYTE_W-1:0]     flags;
    res_t                  hdr_res, flg_res, dat_res;

    always_comb
    begin
        fl_ext   = EXT_W'(frame_length_reg);
        if (fl_ext == '0)
            flen_ext = EXT_W'(1);
        else if (fl_ext > CNT_MAX)
            flen_ext = CNT_MAX;
        else
            flen_ext = fl_ext;
        flen     = flen_ext[FW-1:0];
        psz      = (packet_size_reg < PKT_SIZE_MIN) ? PKT_SIZE_MIN : packet_size_reg;
        room     = psz - HDR_BYTES;
        start    = (pkt_pos_reg == '0);
        fp0      = (frame_pos_reg >= flen) ? '0 : frame_pos_reg;
        remain   = flen - fp0;
        remain_c = CMP_W'(remain);
        eof      = (remain_c <= CMP_W'(room));
        take     = eof ? remain_c[PKT_SIZE_W-1:0] : room;
        new_len  = take + HDR_BYTES;
        fid_new  = (fp0 == '0) ? ~frame_id_reg : frame_id_reg;
        flags          = '0;
        flags[FID_POS] = fid_new;
        flags[EOF_POS] = eof;
        len_eff  = start ? new_len : cur_len_reg;
        pp_base  = start ? HDR_BYTES : pkt_pos_reg;
        pp_inc   = pp_base + PKT_SIZE_W'(1);
        fp_base  = start ? fp0 : frame_pos_reg;
        fp_inc   = fp_base + FW'(1);
        pkt_end  = (pp_inc >= len_eff);
        buf_idx  = start ? toggle_reg : ~toggle_reg;

        hdr_res = '{out_byte: HDR_LEN, packet_end: 1'b0, packet_length: len_eff,
                    buffer_index: buf_idx, run_last: 1'b0};
        flg_res = '{out_byte: flags, packet_end: 1'b0, packet_length: len_eff,
                    buffer_index: buf_idx, run_last: 1'b0};
        dat_res = '{out_byte: s_tdata, packet_end: pkt_end, packet_length: len_eff,
                    buffer_index: buf_idx, run_last: 1'b1};
    end

    assign load     = !out_valid_reg || m_tready;
    assign s_tready = (q_cnt_reg == 2'd0) && load;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        frame_pos_next = frame_pos_reg;
        pkt_pos_next   = pkt_pos_reg;
        frame_id_next  = frame_id_reg;
        toggle_next    = toggle_reg;
        cur_len_next   = cur_len_reg;
        if (accept)
        begin
            cur_len_next   = len_eff;
            pkt_pos_next   = pkt_end ? '0 : pp_inc;
            frame_pos_next = (pkt_end && (fp_inc >= flen)) ? '0 : fp_inc;
            if (start)
            begin
                frame_id_next = fid_new;
                toggle_next   = ~toggle_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        q_cnt_next     = q_cnt_reg;
        out_next       = out_reg;
        q0_next        = q0_reg;
        q1_next        = q1_reg;
        if ((q_cnt_reg != 2'd0) && load)
        begin
            out_next       = q0_reg;
            q0_next        = q1_reg;
            q_cnt_next     = q_cnt_reg - 2'd1;
            out_valid_next = 1'b1;
        end
        else if (accept)
        begin
            out_valid_next = 1'b1;
            if (start)
            begin
                out_next   = hdr_res;
                q0_next    = flg_res;
                q1_next    = dat_res;
                q_cnt_next = 2'd2;
            end
            else
            begin
                out_next = dat_res;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LEN_RST;
            packet_size_reg  <= PKT_SIZE_RST;
            frame_pos_reg    <= '0;
            pkt_pos_reg      <= '0;
            frame_id_reg     <= 1'b1;
            toggle_reg       <= 1'b0;
            cur_len_reg      <= '0;
            out_valid_reg    <= 1'b0;
            q_cnt_reg        <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FRAME_LEN: frame_length_reg <= cfg_data[FRAME_LEN_W-1:0];
                    CFG_PKT_SIZE:  packet_size_reg  <= cfg_data[PKT_SIZE_W-1:0];
                    default:       ;
                endcase
            end
            frame_pos_reg <= frame_pos_next;
            pkt_pos_reg   <= pkt_pos_next;
            frame_id_reg  <= frame_id_next;
            toggle_reg    <= toggle_next;
            cur_len_reg   <= cur_len_next;
            out_valid_reg <= out_valid_next;
            q_cnt_reg     <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        q0_reg  <= q0_next;
        q1_reg  <= q1_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - BYTE_W - PKT_SIZE_W - 1)'(0), out_reg.packet_length,
                       out_reg.packet_end, out_reg.out_byte};
    assign m_tlast  = out_reg.run_last;
    assign m_tuser  = out_reg.buffer_index;

endmodule

// ===== design/uvcpk_checker.sv =====
`timescale 1ns / 1ps
`include "uvc_payload_packetizer_assert.svh"

module uvcpk_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [uvcpk_pkg::TDATA_W-1:0]    m_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic                             m_tlast,
    input logic                             m_tuser
);
    import uvcpk_pkg::*;

    logic stalled;
    logic in_xfer;
    logic end_flag;

    assign stalled  = m_tvalid && !m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign end_flag = m_tdata[BYTE_W];

    `UVCPK_ASSERT_NEXT(a_out_hold, stalled,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
        "output changed while stalled")
    `UVCPK_ASSERT(a_no_take_on_stall, s_tready |-> !stalled,
        "input taken while output stalled")
    `UVCPK_ASSERT(a_end_is_data, (m_tvalid && end_flag) |-> m_tlast,
        "packet end on a header byte")
    `UVCPK_ASSERT_NEXT(a_in_to_out, in_xfer, m_tvalid,
        "no output after input transfer")

endmodule

bind uvc_payload_packetizer uvcpk_checker u_uvcpk_checker (.*);
